// ===== rtl/core/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bit-level I2C master core: request and result item types,
// command codes and sequencing constants. No dependencies.
package i2cm_pkg;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam int unsigned PHASE_W     = 5;
    localparam int unsigned TICK_W      = 16;
    localparam logic [PHASE_W-1:0] BYTE_PHASES = 5'd28;
    localparam logic [PHASE_W-1:0] EDGE_PHASES = 5'd3;
    localparam logic [PHASE_W-1:0] LAST_BIT_PHASE = 5'd24;
    localparam logic [PHASE_W-1:0] REL_PHASE  = 5'd25;
    localparam logic [PHASE_W-1:0] HIGH_PHASE = 5'd26;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd10;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } req_item_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } tick_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_released;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
        logic       cmd_refused;
    } res_item_t;

endpackage

// ===== rtl/core/i2c_bit_level_master_core.sv =====
`timescale 1ns / 1ps
// Bit-level I2C master core, top level. Instantiates i2cm_front and
// i2cm_back; types and constants come from i2cm_pkg.
//
// Usage: each request on the req channel is one timebase tick. Its req_type
// may carry a start, stop, write byte or read byte command; sda_in is the
// sampled bus level. For every request exactly one result comes out on the
// res channel with the SCL/SDA levels to drive, busy, a done pulse, the
// received byte, the acknowledge status and a refused flag.
// A request is taken at a clock edge where req_valid is high and req_stall
// low; results move the same way on res_valid and res_stall.
// A request passes through the request queue, then through the sequencer
// into the result register. Throughput is one request per cycle while the
// receiver does not stall. When the receiver stalls, the result register
// holds and the queue of QUEUE_DEPTH entries fills; req_stall rises once
// it is full. Reset empties the queue, drops res_valid, releases SCL and
// SDA high and sets the phase length register to ten ticks. cfg_we writes
// phase_ticks.
module i2c_bit_level_master_core #(
    parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  i2cm_pkg::req_item_t  req_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output i2cm_pkg::res_item_t  res_data,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata
);

    logic                 tick_valid;
    logic                 tick_pop;
    i2cm_pkg::tick_item_t tick_data;

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .tick_valid (tick_valid),
        .tick_pop   (tick_pop),
        .tick_data  (tick_data)
    );

    i2cm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .tick_valid (tick_valid),
        .tick_pop   (tick_pop),
        .tick_data  (tick_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

// ===== rtl/core/i2cm_front.sv =====
`timescale 1ns / 1ps
// Front end of the I2C master core: accepts requests, decodes the command
// and holds decoded ticks in a small queue. Depends on i2cm_pkg.
module i2cm_front #(
    parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  i2cm_pkg::req_item_t   req_data,
    output logic                  tick_valid,
    input  logic                  tick_pop,
    output i2cm_pkg::tick_item_t  tick_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    i2cm_pkg::tick_item_t store_reg [DEPTH];
    i2cm_pkg::tick_item_t decoded;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    always_comb
    begin
        decoded.tx_byte   = req_data.tx_byte;
        decoded.send_nack = req_data.send_nack;
        decoded.sda_in    = req_data.sda_in;
        case (req_data.req_type)
            i2cm_pkg::REQ_START: decoded.cmd = i2cm_pkg::CMD_START;
            i2cm_pkg::REQ_STOP:  decoded.cmd = i2cm_pkg::CMD_STOP;
            i2cm_pkg::REQ_WRITE: decoded.cmd = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::REQ_READ:  decoded.cmd = i2cm_pkg::CMD_READ;
            default:             decoded.cmd = i2cm_pkg::CMD_IDLE;
        endcase
    end

    assign req_stall  = (count_reg == CNT_FULL);
    assign tick_valid = (count_reg != '0);
    assign tick_data  = store_reg[rd_ptr_reg];
    assign push = req_valid && !req_stall;
    assign pop  = tick_pop && tick_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/core/i2cm_back.sv =====
`timescale 1ns / 1ps
// Back end of the I2C master core: the phase sequencer, the phase length
// register and the result register. Depends on i2cm_pkg.
module i2cm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    input  logic                  tick_valid,
    output logic                  tick_pop,
    input  i2cm_pkg::tick_item_t  tick_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output i2cm_pkg::res_item_t   res_data
);

    localparam int unsigned PW = i2cm_pkg::PHASE_W;
    localparam int unsigned TW = i2cm_pkg::TICK_W;

    i2cm_pkg::cmd_t   cmd_reg, cmd_next;
    logic [PW-1:0]    phase_reg, phase_next;
    logic [TW-1:0]    tick_reg, tick_next;
    logic [1:0]       sub_reg, sub_next;
    logic [7:0]       shift_reg, shift_next;
    logic             nack_reg, nack_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             rel_reg, rel_next;
    logic             ack_reg, ack_next;
    logic [7:0]       rx_reg, rx_next;
    logic [TW-1:0]    phase_ticks_reg;
    logic             res_valid_reg;
    i2cm_pkg::res_item_t res_reg, res_next;

    logic [TW-1:0]    limit;
    logic [TW:0]      tick_inc;
    logic [PW-1:0]    ph_new;
    logic [PW-1:0]    ph_count;
    logic [PW-1:0]    enter_ph;
    i2cm_pkg::cmd_t   enter_cmd;
    logic             do_enter;
    logic [1:0]       sub_new;
    logic             refused;
    logic             done;

    assign tick_pop  = tick_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign limit     = (phase_ticks_reg == '0) ? TW'(1) : phase_ticks_reg;
    assign tick_inc  = {1'b0, tick_reg} + 1'b1;
    assign ph_new    = phase_reg + 1'b1;
    assign ph_count  = (cmd_reg == i2cm_pkg::CMD_WRITE || cmd_reg == i2cm_pkg::CMD_READ)
                       ? i2cm_pkg::BYTE_PHASES : i2cm_pkg::EDGE_PHASES;

    always_comb
    begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        sub_next   = sub_reg;
        shift_next = shift_reg;
        nack_next  = nack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rel_next   = rel_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        refused    = 1'b0;
        done       = 1'b0;
        do_enter   = 1'b0;
        enter_cmd  = cmd_reg;
        enter_ph   = ph_new;
        sub_new    = '0;

        if (cmd_reg != i2cm_pkg::CMD_IDLE)
        begin
            refused = (tick_data.cmd != i2cm_pkg::CMD_IDLE);
            if (tick_inc >= {1'b0, limit})
            begin
                tick_next = '0;
                if (ph_new >= ph_count)
                begin
                    cmd_next   = i2cm_pkg::CMD_IDLE;
                    phase_next = '0;
                    done       = 1'b1;
                end
                else
                begin
                    phase_next = ph_new;
                    do_enter   = 1'b1;
                end
            end
            else
            begin
                tick_next = tick_inc[TW-1:0];
            end
        end
        else if (tick_data.cmd != i2cm_pkg::CMD_IDLE)
        begin
            cmd_next   = tick_data.cmd;
            phase_next = '0;
            tick_next  = '0;
            enter_cmd  = tick_data.cmd;
            enter_ph   = '0;
            do_enter   = 1'b1;
            if (tick_data.cmd == i2cm_pkg::CMD_WRITE)
            begin
                shift_next = tick_data.tx_byte;
                ack_next   = 1'b0;
            end
            else if (tick_data.cmd == i2cm_pkg::CMD_READ)
            begin
                nack_next = tick_data.send_nack;
                rx_next   = '0;
            end
        end

        if (enter_ph == PW'(1))
        begin
            sub_new = '0;
        end
        else
        begin
            sub_new = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
        end

        if (do_enter)
        begin
            case (enter_cmd)
                i2cm_pkg::CMD_START,
                i2cm_pkg::CMD_STOP:
                begin
                    rel_next = 1'b0;
                    if (enter_ph == '0)
                    begin
                        sda_next = (enter_cmd == i2cm_pkg::CMD_START);
                    end
                    else if (enter_ph == PW'(1))
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        sda_next = (enter_cmd == i2cm_pkg::CMD_STOP);
                    end
                end
                i2cm_pkg::CMD_WRITE:
                begin
                    if (enter_ph == '0)
                    begin
                        rel_next = 1'b0;
                        scl_next = 1'b0;
                    end
                    else if (enter_ph <= i2cm_pkg::LAST_BIT_PHASE)
                    begin
                        sub_next = sub_new;
                        if (sub_new == 2'd0)
                        begin
                            sda_next   = shift_next[7];
                            shift_next = {shift_next[6:0], 1'b0};
                        end
                        else
                        begin
                            scl_next = (sub_new == 2'd1);
                        end
                    end
                    else if (enter_ph == i2cm_pkg::REL_PHASE)
                    begin
                        rel_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    else if (enter_ph == i2cm_pkg::HIGH_PHASE)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        ack_next = tick_data.sda_in;
                        scl_next = 1'b0;
                    end
                end
                i2cm_pkg::CMD_READ:
                begin
                    if (enter_ph == '0)
                    begin
                        rel_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    else if (enter_ph <= i2cm_pkg::LAST_BIT_PHASE)
                    begin
                        sub_next = sub_new;
                        if (sub_new == 2'd0)
                        begin
                            rx_next = {rx_next[6:0], tick_data.sda_in};
                        end
                        else
                        begin
                            scl_next = (sub_new == 2'd2);
                        end
                    end
                    else if (enter_ph == i2cm_pkg::REL_PHASE)
                    begin
                        rel_next = 1'b0;
                        scl_next = 1'b0;
                        sda_next = nack_next;
                    end
                    else if (enter_ph == i2cm_pkg::HIGH_PHASE)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                default:
                begin
                    scl_next = scl_reg;
                end
            endcase
        end

        res_next.scl_level    = scl_next;
        res_next.sda_level    = sda_next;
        res_next.sda_released = rel_next;
        res_next.busy_res     = (cmd_next != i2cm_pkg::CMD_IDLE);
        res_next.done_res     = done;
        res_next.rx_byte      = rx_next;
        res_next.ack_missing  = ack_next;
        res_next.cmd_refused  = refused;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg         <= i2cm_pkg::CMD_IDLE;
            phase_reg       <= '0;
            tick_reg        <= '0;
            sub_reg         <= '0;
            shift_reg       <= '0;
            nack_reg        <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            rel_reg         <= 1'b0;
            ack_reg         <= 1'b0;
            rx_reg          <= '0;
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                phase_ticks_reg <= cfg_wdata;
            end
            if (tick_pop)
            begin
                cmd_reg   <= cmd_next;
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                sub_reg   <= sub_next;
                shift_reg <= shift_next;
                nack_reg  <= nack_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                rel_reg   <= rel_next;
                ack_reg   <= ack_next;
                rx_reg    <= rx_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/core/i2cm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the bit-level I2C master core, bound to the top
// level below. Depends on i2cm_pkg.
module i2cm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input i2cm_pkg::res_item_t res_data
);

    property p_res_hold;
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data);
    endproperty

    property p_done_not_busy;
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_data.done_res |-> !res_data.busy_res;
    endproperty

    property p_refused_busy;
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_data.cmd_refused |-> res_data.busy_res || res_data.done_res;
    endproperty

    a_res_hold: assert property (p_res_hold)
        else $error("Stalled result changed or was dropped.");
    a_done_not_busy: assert property (p_done_not_busy)
        else $error("Done pulse shown while still busy.");
    a_refused_busy: assert property (p_refused_busy)
        else $error("Command refused while the sequencer was idle.");

endmodule

bind i2c_bit_level_master_core i2cm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
